@@ rtl/core/pac_pkg.sv @@
// shared types, widths and register codes for the pressure action classifier
`default_nettype none

package pac_pkg;

    localparam int unsigned P_W     = 11;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned STEP_W  = 7;
    localparam int unsigned HOLD_W  = 16;
    localparam int unsigned ACT_W   = 3;
    localparam int unsigned WHEEL_W = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef logic signed [P_W-1:0] t_pressure;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE   = 3'd0,
        ACT_LEFT   = 3'd1,
        ACT_DOUBLE = 3'd2,
        ACT_RIGHT  = 3'd3,
        ACT_UP     = 3'd4,
        ACT_DOWN   = 3'd5
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_TH   = 3'd0,
        CFG_DOUBLE_TH = 3'd1,
        CFG_RIGHT_TH  = 3'd2,
        CFG_UP_TH     = 3'd3,
        CFG_DOWN_TH   = 3'd4,
        CFG_STEP      = 3'd5,
        CFG_SCROLL_ON = 3'd6,
        CFG_HOLDOFF   = 3'd7
    } t_cfg_idx;

    localparam t_pressure         RST_LEFT_TH   = 11'sd10;
    localparam t_pressure         RST_DOUBLE_TH = 11'sd15;
    localparam t_pressure         RST_RIGHT_TH  = -11'sd10;
    localparam t_pressure         RST_UP_TH     = -11'sd5;
    localparam t_pressure         RST_DOWN_TH   = 11'sd5;
    localparam logic [STEP_W-1:0] RST_STEP      = 7'd1;
    localparam logic              RST_SCROLL_ON = 1'b1;
    localparam logic [HOLD_W-1:0] RST_HOLDOFF   = 16'd500;

endpackage

`default_nettype wire

@@ rtl/core/pac_channels.sv @@
// valid/ready channel interfaces for pressure samples and actions
`default_nettype none

interface pac_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [pac_pkg::P_W-1:0]      pressure_delta;
    logic        [pac_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, output pressure_delta, output now_ms, input ready);
    modport sink   (input valid, input pressure_delta, input now_ms, output ready);
endinterface

interface pac_action_if;
    logic                                valid;
    logic                                ready;
    logic        [pac_pkg::ACT_W-1:0]    action;
    logic signed [pac_pkg::WHEEL_W-1:0]  wheel;

    modport source (output valid, output action, output wheel, input ready);
    modport sink   (input valid, input action, input wheel, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pressure_action_classifier.sv @@
// pressure action classifier: samples in, click and scroll actions out
//
// i_in carries one pressure sample (baseline-corrected, signed) and a
// millisecond timestamp per beat; o_out returns exactly one beat per
// sample with the action code and the wheel amount, in order.
// a sample is registered on acceptance, classified in the next cycle and
// lands in the output register once the output stage can advance. one
// beat per cycle is sustained while the receiver holds o_out.ready high;
// the click time register is updated in the same cycle that classifies a
// sample, so the next sample always sees it.
// when the receiver stalls, the output register holds its beat and the
// input register keeps one more; i_in.ready drops only when both are full.
// the config port (i_cfg_we, i_cfg_idx, i_cfg_data) writes one register
// per cycle; it must be used only while no beats are in flight, which
// the block does not enforce. synchronous reset clears both stages,
// restores the register defaults and sets the last click time to zero.
`default_nettype none

module pressure_action_classifier (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pac_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [pac_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    pac_sample_if.sink                             i_in,
    pac_action_if.source                           o_out
);

    pac_pkg::t_pressure                   r_left_th;
    pac_pkg::t_pressure                   r_double_th;
    pac_pkg::t_pressure                   r_right_th;
    pac_pkg::t_pressure                   r_up_th;
    pac_pkg::t_pressure                   r_down_th;
    logic [pac_pkg::STEP_W-1:0]           r_step;
    logic                                 r_scroll_on;
    logic [pac_pkg::HOLD_W-1:0]           r_holdoff;

    logic                                 r_s1_valid;
    pac_pkg::t_pressure                   r_s1_p;
    logic [pac_pkg::TIME_W-1:0]           r_s1_now;
    logic [pac_pkg::TIME_W-1:0]           r_last_click;

    logic                                 r_out_valid;
    pac_pkg::t_action                     r_out_action;
    logic signed [pac_pkg::WHEEL_W-1:0]   r_out_wheel;

    logic                                 s1_adv;
    logic [pac_pkg::TIME_W-1:0]           elapsed;
    logic                                 free;
    logic                                 click;
    pac_pkg::t_action                     n_action;
    logic signed [pac_pkg::WHEEL_W-1:0]   n_wheel;
    logic signed [pac_pkg::WHEEL_W-1:0]   step_s;

    assign s1_adv     = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || s1_adv;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_th   <= pac_pkg::RST_LEFT_TH;
            r_double_th <= pac_pkg::RST_DOUBLE_TH;
            r_right_th  <= pac_pkg::RST_RIGHT_TH;
            r_up_th     <= pac_pkg::RST_UP_TH;
            r_down_th   <= pac_pkg::RST_DOWN_TH;
            r_step      <= pac_pkg::RST_STEP;
            r_scroll_on <= pac_pkg::RST_SCROLL_ON;
            r_holdoff   <= pac_pkg::RST_HOLDOFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pac_pkg::CFG_LEFT_TH:   r_left_th   <= i_cfg_data[pac_pkg::P_W-1:0];
                pac_pkg::CFG_DOUBLE_TH: r_double_th <= i_cfg_data[pac_pkg::P_W-1:0];
                pac_pkg::CFG_RIGHT_TH:  r_right_th  <= i_cfg_data[pac_pkg::P_W-1:0];
                pac_pkg::CFG_UP_TH:     r_up_th     <= i_cfg_data[pac_pkg::P_W-1:0];
                pac_pkg::CFG_DOWN_TH:   r_down_th   <= i_cfg_data[pac_pkg::P_W-1:0];
                pac_pkg::CFG_STEP:      r_step      <= i_cfg_data[pac_pkg::STEP_W-1:0];
                pac_pkg::CFG_SCROLL_ON: r_scroll_on <= i_cfg_data[0];
                pac_pkg::CFG_HOLDOFF:   r_holdoff   <= i_cfg_data[pac_pkg::HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // classification
    assign elapsed = r_s1_now - r_last_click;
    assign free    = elapsed >= {{(pac_pkg::TIME_W-pac_pkg::HOLD_W){1'b0}}, r_holdoff};
    assign step_s  = $signed({1'b0, r_step});

    always_comb begin
        n_action = pac_pkg::ACT_NONE;
        n_wheel  = '0;
        click    = 1'b0;
        if (free) begin
            if (r_s1_p > r_double_th) begin
                n_action = pac_pkg::ACT_DOUBLE;
                click    = 1'b1;
            end else if (r_s1_p > r_left_th) begin
                n_action = pac_pkg::ACT_LEFT;
                click    = 1'b1;
            end else if (r_s1_p < r_right_th) begin
                n_action = pac_pkg::ACT_RIGHT;
                click    = 1'b1;
            end else if (r_scroll_on) begin
                if (r_s1_p < r_up_th) begin
                    n_action = pac_pkg::ACT_UP;
                    n_wheel  = step_s;
                end else if (r_s1_p > r_down_th) begin
                    n_action = pac_pkg::ACT_DOWN;
                    n_wheel  = -step_s;
                end
            end
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_p   <= i_in.pressure_delta;
            r_s1_now <= i_in.now_ms;
        end
    end

    // last click time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_click <= '0;
        end else if (r_s1_valid && s1_adv && click) begin
            r_last_click <= r_s1_now;
        end
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_action <= n_action;
            r_out_wheel  <= n_wheel;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.action = r_out_action;
    assign o_out.wheel  = r_out_wheel;

`ifndef SYNTHESIS
    a_wheel_only_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.action != pac_pkg::ACT_UP && o_out.action != pac_pkg::ACT_DOWN)
        |-> (o_out.wheel == '0))
        else $error("wheel nonzero on a non-scroll beat");

    a_click_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_adv && click) |=> (r_last_click == $past(r_s1_now)))
        else $error("click time not captured");

    a_click_not_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_adv && !free) |=> (r_out_action == pac_pkg::ACT_NONE))
        else $error("action reported inside hold-off");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out.valid && !r_s1_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

@@ tb/pressure_action_classifier_tb.sv @@
// self-checking testbench for pressure_action_classifier with random stalls and config sweeps
`timescale 1ns / 100ps

module pressure_action_classifier_tb;

    localparam int CLK_PERIOD       = 20;
    localparam int TIMEOUT_NS       = 2_000_000;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int P_MAX            = 1023;
    localparam pac_pkg::t_pressure P_HI = 11'sd1023;
    localparam pac_pkg::t_pressure P_LO = -11'sd1023;

    typedef enum {MODE_RX_HEAVY, MODE_TX_HEAVY, MODE_NO_IDLE} t_idle_mode;

    typedef struct {
        pac_pkg::t_pressure         pressure;
        logic [pac_pkg::TIME_W-1:0] stamp;
    } t_sample_item;

    typedef struct {
        pac_pkg::t_action                   action;
        logic signed [pac_pkg::WHEEL_W-1:0] wheel;
    } t_action_beat;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [pac_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [pac_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    pac_sample_if sample_ch ();
    pac_action_if action_ch ();

    pressure_action_classifier u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (sample_ch),
        .o_out      (action_ch)
    );

    // mirror of the block's registers and click time
    pac_pkg::t_pressure         th_left   = pac_pkg::RST_LEFT_TH;
    pac_pkg::t_pressure         th_double = pac_pkg::RST_DOUBLE_TH;
    pac_pkg::t_pressure         th_right  = pac_pkg::RST_RIGHT_TH;
    pac_pkg::t_pressure         th_up     = pac_pkg::RST_UP_TH;
    pac_pkg::t_pressure         th_down   = pac_pkg::RST_DOWN_TH;
    logic [pac_pkg::STEP_W-1:0] wheel_step = pac_pkg::RST_STEP;
    logic                       scroll_en = pac_pkg::RST_SCROLL_ON;
    logic [pac_pkg::HOLD_W-1:0] holdoff_ms = pac_pkg::RST_HOLDOFF;
    logic [pac_pkg::TIME_W-1:0] last_click_ms = '0;

    t_sample_item               sample_q[$];
    t_action_beat               action_q[$];
    int                         samples_queued = 0;
    int                         samples_taken = 0;
    int                         failures = 0;
    logic [pac_pkg::TIME_W-1:0] clock_ms = '0;

    t_idle_mode idle_mode = MODE_RX_HEAVY;
    int         tx_gap_pct = 15;
    int         rx_stall_pct = 46;
    int         long_hold_left;
    logic       long_hold_done;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_action_beat classify_sample(input pac_pkg::t_pressure p,
                                                     input logic [pac_pkg::TIME_W-1:0] stamp);
        t_action_beat               beat;
        logic [pac_pkg::TIME_W-1:0] elapsed;
        beat.action = pac_pkg::ACT_NONE;
        beat.wheel  = '0;
        elapsed     = stamp - last_click_ms;
        if (elapsed >= {16'd0, holdoff_ms}) begin
            if (p > th_double) begin
                beat.action = pac_pkg::ACT_DOUBLE;
            end else if (p > th_left) begin
                beat.action = pac_pkg::ACT_LEFT;
            end else if (p < th_right) begin
                beat.action = pac_pkg::ACT_RIGHT;
            end
            if (beat.action != pac_pkg::ACT_NONE) begin
                last_click_ms = stamp;
            end else if (scroll_en) begin
                if (p < th_up && p >= th_right) begin
                    beat.action = pac_pkg::ACT_UP;
                    beat.wheel  = {1'b0, wheel_step};
                end else if (p > th_down && p <= th_left) begin
                    beat.action = pac_pkg::ACT_DOWN;
                    beat.wheel  = -{1'b0, wheel_step};
                end
            end
        end
        return beat;
    endfunction

    function automatic pac_pkg::t_pressure pick_pressure();
        int v;
        case ($urandom_range(0, 3))
            0, 1: begin
                case ($urandom_range(0, 4))
                    0: v = int'(th_left);
                    1: v = int'(th_double);
                    2: v = int'(th_right);
                    3: v = int'(th_up);
                    default: v = int'(th_down);
                endcase
                v = v + int'($urandom_range(0, 4)) - 2;
            end
            2: v = int'($urandom_range(0, 2 * P_MAX)) - P_MAX;
            default: begin
                case ($urandom_range(0, 2))
                    0: v = -P_MAX;
                    1: v = P_MAX;
                    default: v = 0;
                endcase
            end
        endcase
        if (v > P_MAX) v = P_MAX;
        if (v < -P_MAX) v = -P_MAX;
        return pac_pkg::t_pressure'(v);
    endfunction

    task automatic add_sample(input pac_pkg::t_pressure p,
                              input logic [pac_pkg::TIME_W-1:0] stamp);
        t_sample_item item;
        item.pressure = p;
        item.stamp    = stamp;
        sample_q.push_back(item);
        samples_queued++;
        clock_ms = stamp;
    endtask

    task automatic add_random_samples(input int n);
        logic [pac_pkg::TIME_W-1:0] dt;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 31))
                0: dt = '0;
                1: dt = $urandom;
                default: dt = $urandom_range(0, 2 * int'(holdoff_ms) + 2);
            endcase
            add_sample(pick_pressure(), clock_ms + dt);
        end
    endtask

    task automatic write_reg(input pac_pkg::t_cfg_idx idx,
                             input logic [pac_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            pac_pkg::CFG_LEFT_TH:   th_left    = data[pac_pkg::P_W-1:0];
            pac_pkg::CFG_DOUBLE_TH: th_double  = data[pac_pkg::P_W-1:0];
            pac_pkg::CFG_RIGHT_TH:  th_right   = data[pac_pkg::P_W-1:0];
            pac_pkg::CFG_UP_TH:     th_up      = data[pac_pkg::P_W-1:0];
            pac_pkg::CFG_DOWN_TH:   th_down    = data[pac_pkg::P_W-1:0];
            pac_pkg::CFG_STEP:      wheel_step = data[pac_pkg::STEP_W-1:0];
            pac_pkg::CFG_SCROLL_ON: scroll_en  = data[0];
            pac_pkg::CFG_HOLDOFF:   holdoff_ms = data[pac_pkg::HOLD_W-1:0];
            default: ;
        endcase
    endtask

    // bits above each register's width carry junk
    task automatic program_setting(input pac_pkg::t_pressure l, input pac_pkg::t_pressure d,
                                   input pac_pkg::t_pressure r, input pac_pkg::t_pressure u,
                                   input pac_pkg::t_pressure dn,
                                   input logic [pac_pkg::STEP_W-1:0] step, input logic on,
                                   input logic [pac_pkg::HOLD_W-1:0] hold);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(pac_pkg::CFG_LEFT_TH, {junk[15:11], l});
        write_reg(pac_pkg::CFG_DOUBLE_TH, {junk[14:10], d});
        write_reg(pac_pkg::CFG_RIGHT_TH, {junk[13:9], r});
        write_reg(pac_pkg::CFG_UP_TH, {junk[12:8], u});
        write_reg(pac_pkg::CFG_DOWN_TH, {junk[11:7], dn});
        write_reg(pac_pkg::CFG_STEP, {junk[15:7], step});
        write_reg(pac_pkg::CFG_SCROLL_ON, {junk[15:1], on});
        write_reg(pac_pkg::CFG_HOLDOFF, hold);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_random_setting();
        int                         span;
        int                         th[5];
        logic [31:0]                rnd_hold;
        logic [31:0]                short_hold;
        logic [31:0]                rnd_step;
        logic [pac_pkg::HOLD_W-1:0] hold;
        span = ($urandom_range(0, 1) != 0) ? 30 : P_MAX;
        foreach (th[k]) th[k] = int'($urandom_range(0, 2 * span)) - span;
        // mostly thresholds in their natural order, sometimes scrambled
        if ($urandom_range(0, 3) != 0) th.sort();
        rnd_hold   = $urandom;
        short_hold = $urandom_range(0, 60);
        rnd_step   = $urandom;
        hold = ($urandom_range(0, 3) == 0) ? rnd_hold[pac_pkg::HOLD_W-1:0]
                                           : short_hold[pac_pkg::HOLD_W-1:0];
        program_setting(pac_pkg::t_pressure'(th[3]), pac_pkg::t_pressure'(th[4]),
                        pac_pkg::t_pressure'(th[0]), pac_pkg::t_pressure'(th[1]),
                        pac_pkg::t_pressure'(th[2]),
                        rnd_step[pac_pkg::STEP_W-1:0], $urandom_range(0, 3) != 0, hold);
    endtask

    task automatic wait_drained();
        while (samples_taken != samples_queued || action_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_idle_mode(input t_idle_mode m);
        idle_mode = m;
        case (m)
            MODE_RX_HEAVY: begin tx_gap_pct = 15; rx_stall_pct = 46; end
            MODE_TX_HEAVY: begin tx_gap_pct = 46; rx_stall_pct = 15; end
            default:       begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        endcase
    endtask

    task automatic run_phase(input t_idle_mode m);
        set_idle_mode(m);
        case (m)
            MODE_RX_HEAVY: program_setting(P_HI, P_HI, P_LO, P_HI, P_LO, 7'd127, 1'b1, 16'hFFFF);
            MODE_TX_HEAVY: program_setting(P_LO, P_LO, P_HI, P_LO, P_HI, 7'd0, 1'b0, 16'd0);
            default:       program_setting(P_HI, P_HI, P_LO, P_LO, P_LO, 7'd127, 1'b1, 16'd0);
        endcase
        add_random_samples(40);
        wait_drained();
        repeat (2) begin
            program_random_setting();
            add_random_samples(60);
            wait_drained();
        end
    endtask

    always @(posedge i_clk) begin
        t_sample_item nxt;
        if (!i_rst_n) begin
            sample_ch.valid <= 1'b0;
        end else begin
            if (sample_ch.valid && sample_ch.ready) begin
                action_q.push_back(classify_sample(sample_ch.pressure_delta, sample_ch.now_ms));
                samples_taken++;
            end
            if (!sample_ch.valid || sample_ch.ready) begin
                if (sample_q.size() != 0 && $urandom_range(0, 99) >= tx_gap_pct) begin
                    nxt = sample_q.pop_front();
                    sample_ch.valid          <= 1'b1;
                    sample_ch.pressure_delta <= nxt.pressure;
                    sample_ch.now_ms         <= nxt.stamp;
                end else begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long hold-off once the no-idle phase begins, so the pipeline fills up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            action_ch.ready <= 1'b0;
            long_hold_left  <= 0;
            long_hold_done  <= 1'b0;
        end else if (long_hold_left != 0) begin
            action_ch.ready <= 1'b0;
            long_hold_left  <= long_hold_left - 1;
        end else if (!long_hold_done && idle_mode == MODE_NO_IDLE) begin
            action_ch.ready <= 1'b0;
            long_hold_left  <= LONG_HOLD_CYCLES - 1;
            long_hold_done  <= 1'b1;
        end else begin
            action_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_action_beat exp_beat;
        if (i_rst_n && action_ch.valid && action_ch.ready) begin
            if (action_q.size() == 0) begin
                $error("unexpected beat: action %0d wheel %0d", action_ch.action, action_ch.wheel);
                failures++;
            end else begin
                exp_beat = action_q.pop_front();
                if (action_ch.action !== exp_beat.action) begin
                    $error("action: expected %0d, got %0d", exp_beat.action, action_ch.action);
                    failures++;
                end
                if (action_ch.wheel !== exp_beat.wheel) begin
                    $error("wheel: expected %0d, got %0d", exp_beat.wheel, action_ch.wheel);
                    failures++;
                end
            end
        end
    end

    initial begin
        sample_ch.valid          = 1'b0;
        sample_ch.pressure_delta = '0;
        sample_ch.now_ms         = '0;
        action_ch.ready          = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: hold-off from time zero, priority, band edges, wrap
        add_sample(P_HI, 32'd0);
        add_sample(P_LO, 32'd499);
        add_sample(P_HI, 32'd500);
        add_sample(11'sd20, 32'd999);
        add_sample(11'sd12, 32'd1000);
        add_sample(-11'sd11, 32'd1500);
        add_sample(-11'sd7, 32'd2000);
        add_sample(11'sd7, 32'd2001);
        add_sample(11'sd0, 32'd2002);
        add_sample(-11'sd10, 32'd2003);
        add_sample(11'sd10, 32'd2004);
        add_sample(-11'sd5, 32'd2005);
        add_sample(11'sd5, 32'd2006);
        add_sample(11'sd15, 32'd2007);
        add_sample(P_LO, 32'd2506);
        add_sample(11'sd16, 32'hFFFF_FFF0);
        add_sample(P_LO, 32'h0000_0010);
        add_sample(P_LO, 32'd484);
        add_sample(11'sd11, 32'hFFFF_FFFF);
        add_sample(-11'sd6, 32'd499);
        wait_drained();

        run_phase(MODE_RX_HEAVY);
        run_phase(MODE_TX_HEAVY);
        run_phase(MODE_NO_IDLE);

        repeat (5) @(posedge i_clk);
        if (failures == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule
